@@ hdl/bdeq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdeq_pkg
// shared types and constants for the bounded double-ended queue
// ----------------------------------------------------------------------------
`default_nettype none

package bdeq_pkg;

	localparam int DATA_W  = 32;
	localparam int CMD_W   = 3;
	localparam int LIMIT_W = 5;
	localparam int COUNT_W = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	// command codes carried by a transaction
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_QUERY      = 3'd4
	} cmd_t;

	// operation applied to every cell of one chain in a cycle
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SHIFT_IN,
		OP_SHIFT_OUT,
		OP_APPEND,
		OP_TRIM
	} chain_op_t;

	typedef struct packed {
		chain_op_t                op;
		logic signed [DATA_W-1:0] word;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ hdl/bdeq_cmd_if.sv @@
// ----------------------------------------------------------------------------
// bdeq_cmd_if
// command channel: valid/ready with command code and data word
// ----------------------------------------------------------------------------
`default_nettype none

interface bdeq_cmd_if
	import bdeq_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [DATA_W-1:0] data_word;

	modport source (output valid, output cmd, output data_word, input ready);
	modport sink   (input valid, input cmd, input data_word, output ready);
endinterface

`default_nettype wire

@@ hdl/bdeq_res_if.sv @@
// ----------------------------------------------------------------------------
// bdeq_res_if
// result channel: valid/ready with status and end values
// ----------------------------------------------------------------------------
`default_nettype none

interface bdeq_res_if
	import bdeq_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     accepted;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;
	logic [COUNT_W-1:0]       entry_count;
	logic                     is_empty;
	logic                     is_full;

	modport source (
		output valid, output accepted, output front_value, output back_value,
		output entry_count, output is_empty, output is_full, input ready
	);
	modport sink (
		input valid, input accepted, input front_value, input back_value,
		input entry_count, input is_empty, input is_full, output ready
	);
endinterface

`default_nettype wire

@@ hdl/bdeq_cfg_if.sv @@
// ----------------------------------------------------------------------------
// bdeq_cfg_if
// configuration write channel for the capacity limit
// ----------------------------------------------------------------------------
`default_nettype none

interface bdeq_cfg_if
	import bdeq_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] capacity_limit;

	modport source (output valid, output capacity_limit, input ready);
	modport sink   (input valid, input capacity_limit, output ready);
endinterface

`default_nettype wire

@@ hdl/bounded_double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_unit
// bounded deque of signed 32-bit words built from two rows of cells
// ----------------------------------------------------------------------------
//
//  channel   | dir | payload                                     | handshake
//  ----------+-----+---------------------------------------------+----------
//  cmd_in    | in  | cmd, data_word                              | valid/ready
//  res_out   | out | accepted, front/back value, count, flags    | valid/ready
//  cfg       | in  | capacity_limit                              | valid/ready
//
//  one transaction per cycle while results are taken; the result sits in
//  the output register in the cycle after the command is taken
//  the cell rows update in the same edge, so front and back read from
//  the head cell of each row
//  arst_n clears the count, cell valid bits and result valid; the limit
//  returns to 16; stored words need no clearing
//  a stalled result holds the command channel only while the output
//  register is full and not being taken
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_double_ended_queue_unit
	import bdeq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bdeq_cmd_if.sink   cmd_in,
	bdeq_res_if.source res_out,
	bdeq_cfg_if.sink   cfg
);
	// count width holds DEPTH itself; compare width covers the limit too
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

	// configuration register, always ready
	logic [LIMIT_W-1:0] limit_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg.valid) begin
			limit_q <= cfg.capacity_limit;
		end
	end

	// occupancy and flags before the step
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [LW-1:0] eff_limit;
	logic          full_now;
	logic          empty_now;
	logic          full_next;
	logic          empty_next;

	always_comb begin
		if (LW'(limit_q) > LW'(DEPTH)) begin
			eff_limit = LW'(DEPTH);
		end else begin
			eff_limit = LW'(limit_q);
		end
	end

	assign full_now  = LW'(count_q) >= eff_limit;
	assign empty_now = (count_q == '0);

	// handshake: output register frees up when taken
	logic take;
	logic res_valid_q;

	assign cmd_in.ready = !res_valid_q || res_out.ready;
	assign take         = cmd_in.valid && cmd_in.ready;

	// command decode, one row op per chain
	cell_ctl_t front_ctl;
	cell_ctl_t back_ctl;
	logic      ok;

	always_comb begin
		front_ctl.op   = OP_HOLD;
		back_ctl.op    = OP_HOLD;
		front_ctl.word = cmd_in.data_word;
		back_ctl.word  = cmd_in.data_word;
		count_d        = count_q;
		ok             = 1'b0;
		case (cmd_in.cmd)
			CMD_PUSH_FRONT: begin
				if (!full_now) begin
					ok           = 1'b1;
					front_ctl.op = OP_SHIFT_IN;
					back_ctl.op  = OP_APPEND;
					count_d      = count_q + CW'(1);
				end
			end
			CMD_PUSH_BACK: begin
				if (!full_now) begin
					ok           = 1'b1;
					front_ctl.op = OP_APPEND;
					back_ctl.op  = OP_SHIFT_IN;
					count_d      = count_q + CW'(1);
				end
			end
			CMD_POP_FRONT: begin
				if (!empty_now) begin
					ok           = 1'b1;
					front_ctl.op = OP_SHIFT_OUT;
					back_ctl.op  = OP_TRIM;
					count_d      = count_q - CW'(1);
				end
			end
			CMD_POP_BACK: begin
				if (!empty_now) begin
					ok           = 1'b1;
					front_ctl.op = OP_TRIM;
					back_ctl.op  = OP_SHIFT_OUT;
					count_d      = count_q - CW'(1);
				end
			end
			CMD_QUERY: begin
				ok = 1'b1;
			end
			// unused codes read back like a query but report refusal
			default: begin
				ok = 1'b0;
			end
		endcase
		// nothing moves unless the transaction is taken
		if (!take) begin
			front_ctl.op = OP_HOLD;
			back_ctl.op  = OP_HOLD;
			count_d      = count_q;
		end
	end

	assign empty_next = (count_d == '0);
	assign full_next  = LW'(count_d) >= eff_limit;

	// front row keeps the front at cell 0, back row keeps the back at cell 0
	logic signed [DATA_W-1:0] front_d;
	logic signed [DATA_W-1:0] back_d;
	logic                     front_head_valid;
	logic                     back_head_valid;

	bdeq_chain #(
		.DEPTH (DEPTH)
	) u_front_chain (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (front_ctl),
		.head_data_d  (front_d),
		.head_valid_q (front_head_valid)
	);

	bdeq_chain #(
		.DEPTH (DEPTH)
	) u_back_chain (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (back_ctl),
		.head_data_d  (back_d),
		.head_valid_q (back_head_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// result register
	logic                     res_ok_q;
	logic signed [DATA_W-1:0] res_front_q;
	logic signed [DATA_W-1:0] res_back_q;
	logic [COUNT_W-1:0]       res_count_q;
	logic                     res_empty_q;
	logic                     res_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_ok_q    <= ok;
			res_front_q <= empty_next ? '0 : front_d;
			res_back_q  <= empty_next ? '0 : back_d;
			res_count_q <= COUNT_W'(count_d);
			res_empty_q <= empty_next;
			res_full_q  <= full_next;
		end
	end

	assign res_out.valid       = res_valid_q;
	assign res_out.accepted    = res_ok_q;
	assign res_out.front_value = res_front_q;
	assign res_out.back_value  = res_back_q;
	assign res_out.entry_count = res_count_q;
	assign res_out.is_empty    = res_empty_q;
	assign res_out.is_full     = res_full_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(count_q) <= LW'(DEPTH))
		else $error("count exceeds depth");

	a_front_head: assert property (@(posedge clk) disable iff (!arst_n)
		front_head_valid == (count_q != '0))
		else $error("front row head disagrees with count");

	a_rows_agree: assert property (@(posedge clk) disable iff (!arst_n)
		front_head_valid == back_head_valid)
		else $error("front and back rows disagree on occupancy");

	a_push_front: assert property (@(posedge clk) disable iff (!arst_n)
		take && (cmd_in.cmd == CMD_PUSH_FRONT) && !full_now
		|=> res_out.valid && (res_out.front_value == $past(cmd_in.data_word)))
		else $error("pushed word not at front");

endmodule

`default_nettype wire

@@ hdl/bdeq_cell.sv @@
// ----------------------------------------------------------------------------
// bdeq_cell
// one storage cell of a chain: shifts, appends or trims by neighbor state
// ----------------------------------------------------------------------------
`default_nettype none

module bdeq_cell
	import bdeq_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cell_ctl_t                ctl,
	input  wire logic signed [DATA_W-1:0] left_data,
	input  wire logic                     left_valid,
	input  wire logic signed [DATA_W-1:0] right_data,
	input  wire logic                     right_valid,
	output logic signed [DATA_W-1:0]      data_q,
	output logic                          valid_q,
	output logic signed [DATA_W-1:0]      data_d
);
	logic valid_d;

	always_comb begin
		data_d  = data_q;
		valid_d = valid_q;
		case (ctl.op)
			OP_SHIFT_IN: begin
				data_d  = left_data;
				valid_d = left_valid;
			end
			OP_SHIFT_OUT: begin
				data_d  = right_data;
				valid_d = right_valid;
			end
			// first empty cell behind the occupied run takes the word
			OP_APPEND: begin
				if (!valid_q && left_valid) begin
					data_d  = ctl.word;
					valid_d = 1'b1;
				end
			end
			// last occupied cell drops out
			OP_TRIM: begin
				if (valid_q && !right_valid) begin
					valid_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

endmodule

`default_nettype wire

@@ hdl/bdeq_chain.sv @@
// ----------------------------------------------------------------------------
// bdeq_chain
// row of cells holding the queue in order, cell 0 at the chain's own end
// ----------------------------------------------------------------------------
`default_nettype none

module bdeq_chain
	import bdeq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cell_ctl_t                ctl,
	output logic signed [DATA_W-1:0]      head_data_d,
	output logic                          head_valid_q
);
	logic signed [DATA_W-1:0] data_q [DEPTH];
	logic signed [DATA_W-1:0] data_d [DEPTH];
	logic                     valid_q [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] l_data;
		logic                     l_valid;
		logic signed [DATA_W-1:0] r_data;
		logic                     r_valid;

		// cell 0 sees the incoming word as an always-occupied left neighbor
		if (i == 0) begin : g_first
			assign l_data  = ctl.word;
			assign l_valid = 1'b1;
		end else begin : g_mid
			assign l_data  = data_q[i-1];
			assign l_valid = valid_q[i-1];
		end

		if (i == DEPTH-1) begin : g_last
			assign r_data  = '0;
			assign r_valid = 1'b0;
		end else begin : g_inner
			assign r_data  = data_q[i+1];
			assign r_valid = valid_q[i+1];
		end

		bdeq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_data   (l_data),
			.left_valid  (l_valid),
			.right_data  (r_data),
			.right_valid (r_valid),
			.data_q      (data_q[i]),
			.valid_q     (valid_q[i]),
			.data_d      (data_d[i])
		);
	end

	assign head_data_d  = data_d[0];
	assign head_valid_q = valid_q[0];

endmodule

`default_nettype wire

@@ dv/tb_bounded_double_ended_queue_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_double_ended_queue_unit
// self-checking bench: a directed table of commands, then random push/pop
// traffic over a series of capacity limits; every result is compared against
// an in-bench deque model or a typed-in status, with random stalls both sides
// ----------------------------------------------------------------------------

module tb_bounded_double_ended_queue_unit
	import bdeq_pkg::*;
;

	// bench geometry and timing
	localparam int QUEUE_DEPTH     = 16;
	localparam int PTR_W           = $clog2(QUEUE_DEPTH);
	localparam int RESET_CYCLES    = 11;
	localparam int IDLE_PERCENT    = 26;
	localparam int SETTLE_CYCLES   = 8;   // lets the result register drain
	localparam int HOLD_CYCLES     = 400; // long result-side hold-off
	localparam int WATCHDOG_CYCLES = 3000;
	localparam int MAX_REPORTS     = 10;

	// random phases: one capacity limit each
	localparam int NUM_PHASES    = 12;
	localparam int PHASE_ITEMS   = 110;
	localparam int HOLD_PHASE    = 1;
	localparam int GAPLESS_FIRST = 4;
	localparam int GAPLESS_LAST  = 5;
	localparam int PAUSE_PHASE   = 7;
	localparam logic [LIMIT_W-1:0] PHASE_LIMITS [0:NUM_PHASES-1] = '{
		5'd16, 5'd31, 5'd1, 5'd17, 5'd0, 5'd8, 5'd3, 5'd16, 5'd2, 5'd12, 5'd5, 5'd16
	};

	// command codes the package leaves unnamed; the block treats them as a
	// query that reports refusal
	localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

	// data extremes
	localparam logic [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
	localparam logic [DATA_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] WORD_NEG1 = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] WORD_ZERO = 32'h0000_0000;

	// one result transaction as seen on the output channel
	typedef struct packed {
		logic                     accepted;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] back_value;
		logic [COUNT_W-1:0]       entry_count;
		logic                     is_empty;
		logic                     is_full;
	} deque_status_t;

	// directed rows: a command checked by the model, a command with its
	// status typed in, or a write of the capacity limit (value in word)
	typedef enum logic [1:0] {
		ROW_STEP,
		ROW_STEP_FIXED,
		ROW_LIMIT
	} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [CMD_W-1:0]   code;
		logic [DATA_W-1:0]  word;
		deque_status_t      status;
	} stimulus_row_t;

	localparam deque_status_t ANY_STATUS = '0;
	localparam int NUM_ROWS = 29;

	localparam stimulus_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
		// straight out of reset: empty, nothing to pop
		'{ROW_STEP_FIXED, CMD_QUERY,      WORD_ZERO, '{1'b1, 32'sd0, 32'sd0, 5'd0, 1'b1, 1'b0}},
		'{ROW_STEP_FIXED, CMD_POP_FRONT,  WORD_ZERO, '{1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1, 1'b0}},
		'{ROW_STEP_FIXED, CMD_POP_BACK,   WORD_ZERO, '{1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1, 1'b0}},
		// unused codes report refusal and change nothing
		'{ROW_STEP_FIXED, CMD_SPARE_LO,   WORD_MAX,  '{1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1, 1'b0}},
		'{ROW_STEP_FIXED, CMD_SPARE_HI,   WORD_NEG1, '{1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1, 1'b0}},
		// data extremes through both ends
		'{ROW_STEP_FIXED, CMD_PUSH_BACK,  WORD_MAX,  '{1'b1, WORD_MAX, WORD_MAX,  5'd1, 1'b0, 1'b0}},
		'{ROW_STEP_FIXED, CMD_PUSH_FRONT, WORD_MIN,  '{1'b1, WORD_MIN, WORD_MAX,  5'd2, 1'b0, 1'b0}},
		'{ROW_STEP_FIXED, CMD_PUSH_BACK,  WORD_NEG1, '{1'b1, WORD_MIN, WORD_NEG1, 5'd3, 1'b0, 1'b0}},
		'{ROW_STEP,       CMD_PUSH_FRONT, WORD_ZERO,     ANY_STATUS},
		'{ROW_STEP,       CMD_SPARE_MID,  32'h5A5A_A5A5, ANY_STATUS},
		'{ROW_STEP,       CMD_POP_BACK,   WORD_ZERO,     ANY_STATUS},
		'{ROW_STEP,       CMD_POP_FRONT,  WORD_ZERO,     ANY_STATUS},
		// limit lowered below the count: full, pushes refused, pops still work
		'{ROW_LIMIT,      CMD_QUERY,      32'd1,         ANY_STATUS},
		'{ROW_STEP,       CMD_PUSH_BACK,  32'h1234_5678, ANY_STATUS},
		'{ROW_STEP,       CMD_PUSH_FRONT, 32'h0F0F_0F0F, ANY_STATUS},
		'{ROW_STEP,       CMD_POP_FRONT,  WORD_ZERO,     ANY_STATUS},
		'{ROW_STEP,       CMD_POP_BACK,   WORD_ZERO,     ANY_STATUS},
		// limit of zero: empty and full at once
		'{ROW_LIMIT,      CMD_QUERY,      32'd0,         ANY_STATUS},
		'{ROW_STEP_FIXED, CMD_QUERY,      WORD_ZERO, '{1'b1, 32'sd0, 32'sd0, 5'd0, 1'b1, 1'b1}},
		'{ROW_STEP_FIXED, CMD_PUSH_FRONT, 32'd5,     '{1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1, 1'b1}},
		'{ROW_STEP_FIXED, CMD_PUSH_BACK,  WORD_MIN,  '{1'b0, 32'sd0, 32'sd0, 5'd0, 1'b1, 1'b1}},
		// limits above the depth saturate
		'{ROW_LIMIT,      CMD_QUERY,      32'd31,        ANY_STATUS},
		'{ROW_STEP,       CMD_PUSH_BACK,  32'h5555_5555, ANY_STATUS},
		'{ROW_STEP,       CMD_PUSH_FRONT, 32'hAAAA_AAAA, ANY_STATUS},
		'{ROW_STEP,       CMD_QUERY,      WORD_NEG1,     ANY_STATUS},
		'{ROW_LIMIT,      CMD_QUERY,      32'd17,        ANY_STATUS},
		'{ROW_STEP,       CMD_POP_BACK,   WORD_ZERO,     ANY_STATUS},
		'{ROW_STEP,       CMD_POP_FRONT,  WORD_ZERO,     ANY_STATUS},
		'{ROW_LIMIT,      CMD_QUERY,      32'd16,        ANY_STATUS}
	};

	logic clk = 1'b0;
	logic arst_n;

	bdeq_cmd_if cmd_if ();
	bdeq_res_if res_if ();
	bdeq_cfg_if cfg_if ();

	bounded_double_ended_queue_unit #(
		.DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd_in (cmd_if),
		.res_out(res_if),
		.cfg    (cfg_if)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// deque model: a circular store of its own, its indexes, the count
	// and the capacity limit
	// ------------------------------------------------------------------------
	logic [DATA_W-1:0]  shadow_words [0:QUEUE_DEPTH-1];
	logic [PTR_W-1:0]   shadow_head  = '0; // slot of the front entry
	logic [PTR_W-1:0]   shadow_tail  = '0; // slot just past the back entry
	logic [COUNT_W-1:0] shadow_count = '0;
	logic [LIMIT_W-1:0] shadow_limit = LIMIT_RESET;

	// expected result transactions, oldest first
	deque_status_t status_due [$];

	// side-channel knobs shared with the result sink
	bit          no_gaps   = 1'b0;
	int unsigned hold_left = 0;

	int unsigned mismatch_count = 0;
	int unsigned result_index   = 0;
	int unsigned quiet_cycles   = 0;

	// limits above the depth clamp to the depth
	function automatic logic [LIMIT_W-1:0] effective_limit();
		return (shadow_limit > QUEUE_DEPTH) ? LIMIT_W'(QUEUE_DEPTH) : shadow_limit;
	endfunction

	// apply one command to the shadow deque and return the status after it
	function automatic deque_status_t deque_step(input logic [CMD_W-1:0] code,
			input logic [DATA_W-1:0] word);
		deque_status_t    st;
		logic             was_full;
		logic             was_empty;
		logic [PTR_W-1:0] back_slot;
		was_full  = shadow_count >= effective_limit();
		was_empty = shadow_count == 0;
		st        = '0;
		case (code)
			CMD_PUSH_FRONT: begin
				if (!was_full) begin
					// index arithmetic wraps at the store depth
					shadow_head               = shadow_head - 1'b1;
					shadow_words[shadow_head] = word;
					shadow_count              = shadow_count + 1'b1;
					st.accepted               = 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (!was_full) begin
					shadow_words[shadow_tail] = word;
					shadow_tail               = shadow_tail + 1'b1;
					shadow_count              = shadow_count + 1'b1;
					st.accepted               = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (!was_empty) begin
					shadow_head  = shadow_head + 1'b1;
					shadow_count = shadow_count - 1'b1;
					st.accepted  = 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (!was_empty) begin
					shadow_tail  = shadow_tail - 1'b1;
					shadow_count = shadow_count - 1'b1;
					st.accepted  = 1'b1;
				end
			end
			CMD_QUERY: begin
				st.accepted = 1'b1;
			end
			default: begin
				st.accepted = 1'b0;
			end
		endcase
		back_slot      = shadow_tail - 1'b1;
		st.is_empty    = shadow_count == 0;
		st.is_full     = shadow_count >= effective_limit();
		st.entry_count = shadow_count;
		st.front_value = st.is_empty ? '0 : shadow_words[shadow_head];
		st.back_value  = st.is_empty ? '0 : shadow_words[back_slot];
		return st;
	endfunction

	function automatic string describe_status(input deque_status_t s);
		return $sformatf("acc=%0b front=%0d back=%0d count=%0d empty=%0b full=%0b",
			s.accepted, s.front_value, s.back_value, s.entry_count, s.is_empty, s.is_full);
	endfunction

	// ------------------------------------------------------------------------
	// command side
	// ------------------------------------------------------------------------

	// offer one command, with random idle cycles in front unless no_gaps;
	// valid stays high afterwards so back-to-back commands need no gap
	task automatic send_command(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] word,
			input bit fixed, input deque_status_t fixed_status);
		deque_status_t st;
		if (!no_gaps) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				cmd_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_if.valid     <= 1'b1;
		cmd_if.cmd       <= code;
		cmd_if.data_word <= word;
		do @(posedge clk); while (!cmd_if.ready);
		// the model still runs on typed-in rows to keep its state in step
		st = deque_step(code, word);
		status_due.push_back(fixed ? fixed_status : st);
	endtask

	// stop offering commands, wait until every result is back, and then wait
	// out the settle time so the result register is empty too
	task automatic settle_deque();
		cmd_if.valid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one write on the configuration channel; only called while idle
	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		cfg_if.valid          <= 1'b1;
		cfg_if.capacity_limit <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		shadow_limit = value;
	endtask

	// ------------------------------------------------------------------------
	// result sink: random ready, a gapless window, and a long hold-off that
	// this process counts down itself
	// ------------------------------------------------------------------------
	initial begin : result_sink
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_if.ready <= 1'b0;
				hold_left--;
			end else if (no_gaps) begin
				res_if.ready <= 1'b1;
			end else begin
				res_if.ready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// ------------------------------------------------------------------------
	// result check: every accepted result against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		deque_status_t got;
		deque_status_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.accepted    = res_if.accepted;
			got.front_value = res_if.front_value;
			got.back_value  = res_if.back_value;
			got.entry_count = res_if.entry_count;
			got.is_empty    = res_if.is_empty;
			got.is_full     = res_if.is_full;
			if (status_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("[%0t] result %0d with nothing expected: %s",
						$realtime, result_index, describe_status(got));
			end else begin
				want = status_due.pop_front();
				if (got.accepted !== want.accepted || got.front_value !== want.front_value ||
						got.back_value !== want.back_value ||
						got.entry_count !== want.entry_count ||
						got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("[%0t] result %0d mismatch\n  expected %s\n  actual   %s",
							$realtime, result_index, describe_status(want),
							describe_status(got));
				end
			end
			result_index++;
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long without any transaction on any channel
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("[%0t] watchdog: no transaction for %0d cycles",
					$realtime, WATCHDOG_CYCLES);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : main_sequence
		stimulus_row_t     row;
		bit                grow;
		int unsigned       run_left;
		int unsigned       pick;
		logic [CMD_W-1:0]  code;
		logic [DATA_W-1:0] word;

		// every block input known from time zero
		arst_n                <= 1'b0;
		cmd_if.valid          <= 1'b0;
		cmd_if.cmd            <= CMD_QUERY;
		cmd_if.data_word      <= '0;
		cfg_if.valid          <= 1'b0;
		cfg_if.capacity_limit <= LIMIT_RESET;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < NUM_ROWS; i++) begin
			row = DIRECTED_ROWS[i];
			if (row.kind == ROW_LIMIT) begin
				settle_deque();
				write_limit(row.word[LIMIT_W-1:0]);
			end else begin
				send_command(row.code, row.word, row.kind == ROW_STEP_FIXED, row.status);
			end
		end

		// random phases: runs that lean toward pushing alternate with runs
		// that lean toward popping, so the queue swings between empty and
		// full under each limit; contents carry over, so a lower limit can
		// land below the count
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			settle_deque();
			write_limit(PHASE_LIMITS[phase]);
			no_gaps = (phase >= GAPLESS_FIRST && phase <= GAPLESS_LAST);
			// result side holds off while commands keep coming, so the block
			// fills and stalls its input
			if (phase == HOLD_PHASE)
				hold_left = HOLD_CYCLES;
			grow     = (phase % 2) == 0;
			run_left = $urandom_range(40, 5);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// command side pauses until every result is in
				if (phase == PAUSE_PHASE && n == PHASE_ITEMS / 2)
					settle_deque();
				if (run_left == 0) begin
					grow     = !grow;
					run_left = $urandom_range(40, 5);
				end
				run_left--;

				pick = $urandom_range(99);
				if (pick < 4)
					code = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
				else if (pick < 10)
					code = CMD_QUERY;
				else if ((pick < 72) == grow)
					code = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
				else
					code = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;

				// extremes now and then, otherwise any word
				case ($urandom_range(7))
					0:       word = WORD_MIN;
					1:       word = WORD_MAX;
					2:       word = WORD_ZERO;
					3:       word = WORD_NEG1;
					default: word = $urandom;
				endcase
				send_command(code, word, 1'b0, ANY_STATUS);
			end
		end

		no_gaps = 1'b0;
		settle_deque();

		if (mismatch_count == 0 && status_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
